>>> hw/rtl/osl_pkg.sv
// ----------------------------------------------------------------------------
// osl_pkg
// Shared types and constants for the sorted table lookup block: record
// layout, transaction modes, register indexes and controller states.
// ----------------------------------------------------------------------------
package osl_pkg;

	// default table size in records
	localparam int unsigned OSL_TABLE_DEPTH = 32768;

	// field widths fixed by the interface
	localparam int unsigned OSL_INDEX_W  = 15;
	localparam int unsigned OSL_KEY_W    = 24;
	localparam int unsigned OSL_OFFSET_W = 32;
	localparam int unsigned OSL_COUNT_W  = 16;
	localparam int unsigned OSL_CFG_IDX_W = 1;
	localparam int unsigned OSL_CFG_DATA_W = 32;

	// transaction modes
	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;

	// configuration register indexes
	localparam logic [OSL_CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b0;
	localparam logic [OSL_CFG_IDX_W-1:0] CFG_NAME_BASE   = 1'b1;

	// one stored record
	typedef struct packed {
		logic [OSL_KEY_W-1:0]    key;
		logic [OSL_OFFSET_W-1:0] offset;
	} entry_t;

	// search controller states
	typedef enum logic {
		ST_IDLE,
		ST_SEARCH
	} state_t;

endpackage

>>> hw/rtl/osl_table_mem.sv
// ----------------------------------------------------------------------------
// osl_table_mem
// Record store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module osl_table_mem
	import osl_pkg::*;
#(
	parameter int unsigned DEPTH = OSL_TABLE_DEPTH,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_data
);

	entry_t mem [DEPTH];
	entry_t rd_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

>>> hw/rtl/osl_search_ctrl.sv
// ----------------------------------------------------------------------------
// osl_search_ctrl
// Binary search sequencer: one probe per cycle against the record store,
// bounds kept as [lo, hi_plus1), result held in output registers.
// ----------------------------------------------------------------------------
module osl_search_ctrl
	import osl_pkg::*;
#(
	parameter int unsigned DEPTH = OSL_TABLE_DEPTH,
	parameter int unsigned AW    = $clog2(DEPTH),
	parameter int unsigned CW    = AW + 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    mode,
	input  logic [OSL_KEY_W-1:0]    key,
	input  logic [CW-1:0]           count,
	input  logic [OSL_OFFSET_W-1:0] name_base,
	output logic                    busy,
	output logic                    rd_en,
	output logic [AW-1:0]           rd_addr,
	input  entry_t                  rd_data,
	output logic                    done,
	output logic                    found,
	output logic [OSL_OFFSET_W-1:0] matched_offset,
	output logic [OSL_OFFSET_W-1:0] vendor_address
);

	state_t                  state_q, state_d;
	logic [CW-1:0]           lo_q, hp1_q;
	logic [AW-1:0]           mid_q;
	logic [OSL_KEY_W-1:0]    key_q;
	logic                    done_q, found_q;
	logic [OSL_OFFSET_W-1:0] offset_q, addr_q;

	logic          lookup_go, count_zero, hit, less, empty;
	logic [CW-1:0] mid_inc, mid_ext, nlo, nhp1;
	logic [CW:0]   sum0, sum1;
	logic [AW-1:0] mid0, mid1;
	logic          finish, fin_found;

	// probe compare and bound update
	always_comb begin
		lookup_go  = start && (state_q == ST_IDLE) && (mode == MODE_LOOKUP);
		count_zero = (count == '0);
		hit        = (rd_data.key == key_q);
		less       = (rd_data.key < key_q);
		mid_ext    = CW'(mid_q);
		mid_inc    = mid_ext + CW'(1);
		nlo        = less ? mid_inc : lo_q;
		nhp1       = less ? hp1_q : mid_ext;
		empty      = (nlo >= nhp1);
		sum0       = (CW+1)'(count) - (CW+1)'(1);
		mid0       = sum0[AW:1];
		sum1       = (CW+1)'(nlo) + (CW+1)'(nhp1) - (CW+1)'(1);
		mid1       = sum1[AW:1];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (lookup_go && !count_zero) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (hit || empty) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// read requests and completion
	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = mid0;
		finish    = 1'b0;
		fin_found = 1'b0;
		case (state_q)
			ST_IDLE: begin
				rd_en   = lookup_go && !count_zero;
				rd_addr = mid0;
				finish  = lookup_go && count_zero;
			end
			ST_SEARCH: begin
				rd_en     = !hit && !empty;
				rd_addr   = mid1;
				finish    = hit || empty;
				fin_found = hit;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
		end
	end

	// search bounds and probe address
	always_ff @(posedge clk) begin
		if (lookup_go) begin
			lo_q  <= '0;
			hp1_q <= count;
			mid_q <= mid0;
			key_q <= key;
		end else if (state_q == ST_SEARCH && !hit && !empty) begin
			lo_q  <= nlo;
			hp1_q <= nhp1;
			mid_q <= mid1;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (finish) begin
			found_q  <= fin_found;
			offset_q <= fin_found ? rd_data.offset : '0;
			addr_q   <= fin_found ? (name_base + rd_data.offset) : '0;
		end
	end

	assign busy           = (state_q != ST_IDLE);
	assign done           = done_q;
	assign found          = found_q;
	assign matched_offset = offset_q;
	assign vendor_address = addr_q;

`ifndef SYNTHESIS
	// search interval is never empty while probing
	a_interval: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (hp1_q > lo_q))
		else $error("empty search interval while probing");

	// probed record lies inside the interval
	a_mid_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (mid_ext >= lo_q && mid_ext < hp1_q))
		else $error("probe outside search interval");

	// a lookup either completes at once or starts probing
	a_lookup_progress: assert property (@(posedge clk) disable iff (!arst_n)
		lookup_go |=> (done_q || state_q == ST_SEARCH))
		else $error("lookup transaction lost");

	// a miss returns zero fields
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !found_q) |-> (offset_q == '0 && addr_q == '0))
		else $error("miss with nonzero result fields");
`endif

endmodule

>>> hw/rtl/oui_sorted_table_lookup.sv
// ----------------------------------------------------------------------------
// oui_sorted_table_lookup
// Sorted record table with binary search lookup of 24-bit keys.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken at a clock edge with start high and busy low.
//   mode selects a record write (index, key, name_offset) or a key lookup.
//   A write lands in the record store at that edge, returns no result and
//   leaves busy low, so the next transaction may follow in the next cycle.
//   A lookup raises busy and probes one record per cycle through the
//   single read port of the record store; the next bound depends on each
//   probe, so a lookup takes up to floor(log2(count)) + 1 probes (16 for a
//   full table of 32768), and one lookup runs at a time.
//   A count of zero finishes in the cycle after start.
//   The result (found, matched_offset, vendor_address) shows for exactly one
//   cycle with done high, in the cycle busy drops; the receiver cannot stall.
//   Configuration: cfg_we writes cfg_wdata to register cfg_idx, 0 for the
//   entry count, 1 for the name base; write only while idle.
//   Reset clears the configuration registers and the controller state; record contents are
//   undefined until written.
// ----------------------------------------------------------------------------
module oui_sorted_table_lookup
	import osl_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = OSL_TABLE_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      mode,
	input  logic [OSL_INDEX_W-1:0]    index,
	input  logic [OSL_KEY_W-1:0]      key,
	input  logic [OSL_OFFSET_W-1:0]   name_offset,
	output logic                      done,
	output logic                      found,
	output logic [OSL_OFFSET_W-1:0]   matched_offset,
	output logic [OSL_OFFSET_W-1:0]   vendor_address,
	input  logic                      cfg_we,
	input  logic [OSL_CFG_IDX_W-1:0]  cfg_idx,
	input  logic [OSL_CFG_DATA_W-1:0] cfg_wdata
);

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = AW + 1;

	logic [OSL_COUNT_W-1:0]  entry_count_q;
	logic [OSL_OFFSET_W-1:0] name_base_q;
	logic [CW-1:0]           count_sat;
	logic [16:0]             idx_ext;
	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	entry_t                  wr_data;
	logic                    rd_en;
	logic [AW-1:0]           rd_addr;
	entry_t                  rd_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			name_base_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_ENTRY_COUNT: entry_count_q <= cfg_wdata[OSL_COUNT_W-1:0];
				CFG_NAME_BASE:   name_base_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// entry count saturated at the table depth
	assign count_sat = ({1'b0, entry_count_q} > 17'(TABLE_DEPTH))
		? CW'(TABLE_DEPTH) : CW'(entry_count_q);

	// record write, dropped when the index is past the table
	assign idx_ext        = 17'(index);
	assign wr_en          = start && !busy && (mode == MODE_WRITE)
		&& (idx_ext < 17'(TABLE_DEPTH));
	assign wr_addr        = idx_ext[AW-1:0];
	assign wr_data.key    = key;
	assign wr_data.offset = name_offset;

	osl_table_mem #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	osl_search_ctrl #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.mode           (mode),
		.key            (key),
		.count          (count_sat),
		.name_base      (name_base_q),
		.busy           (busy),
		.rd_en          (rd_en),
		.rd_addr        (rd_addr),
		.rd_data        (rd_data),
		.done           (done),
		.found          (found),
		.matched_offset (matched_offset),
		.vendor_address (vendor_address)
	);

endmodule
